>>> rtl/multichannel_spike_detector_top_assert.svh
// Assertion macros for the spike detector checker.
// Clock and reset are passed in so each use states its own sampling.
`ifndef MULTICHANNEL_SPIKE_DETECTOR_TOP_ASSERT_SVH
`define MULTICHANNEL_SPIKE_DETECTOR_TOP_ASSERT_SVH

// Checked only out of reset.
`define MSD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Types and constants shared by the multichannel spike detector modules.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH     = 2;
    localparam int QPW        = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD     = 8'd0,
        REG_BLANKING      = 8'd1,
        REG_POLARITY_HIGH = 8'd2,
        REG_RUN_NEEDED    = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] threshold;
        logic [15:0] blanking;
        logic        polarity_high;
        logic [7:0]  run_needed;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        threshold:     16'd32768,
        blanking:      16'd100,
        polarity_high: 1'b1,
        run_needed:    8'd3
    };

    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] sample;
        logic        new_scan;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  out_channel;
        logic        spike_found;
        logic [15:0] spike_total;
        logic [31:0] spike_scan;
        logic [31:0] scan_number;
    } t_out_item;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic [3:0]  channel;
        logic        ch_ok;
        logic        beyond;
        logic [31:0] scan;
    } t_q_entry;

    // Per-channel detector state.
    typedef struct packed {
        logic [15:0] since;
        logic [7:0]  run;
        logic [15:0] count;
        logic [31:0] last_scan;
    } t_chan_state;

    localparam t_chan_state CHAN_RESET = '{
        since:     16'hFFFF,
        run:       8'd0,
        count:     16'd0,
        last_scan: 32'd0
    };

    // Queue status seen by the back end.
    typedef struct packed {
        logic     valid;
        t_q_entry head;
    } t_q_head;

endpackage

>>> rtl/msd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_front
// Accepts samples, advances the scan counter and classifies each request.
// ----------------------------------------------------------------------------
module msd_front #(
    parameter int CHANNELS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  msd_pkg::t_in_item i_item,
    input  msd_pkg::t_cfg     i_cfg,
    output logic              o_push,
    output msd_pkg::t_q_entry o_entry
);

    logic [31:0] r_scan;
    logic [31:0] n_scan;
    logic        beyond;

    always_comb begin
        n_scan = r_scan + {31'd0, i_item.new_scan};
        if (i_cfg.polarity_high) begin
            beyond = i_item.sample > i_cfg.threshold;
        end else begin
            beyond = i_item.sample < i_cfg.threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_accept) begin
            r_scan <= n_scan;
        end
    end

    assign o_push          = i_accept;
    assign o_entry.channel = i_item.channel;
    assign o_entry.ch_ok   = (32'(i_item.channel) < CHANNELS);
    assign o_entry.beyond  = beyond;
    assign o_entry.scan    = n_scan;

endmodule

>>> rtl/msd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module msd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  msd_pkg::t_q_entry i_entry,
    input  logic              i_pop,
    output msd_pkg::t_q_head  o_head,
    output logic              o_full
);

    msd_pkg::t_q_entry      r_mem [msd_pkg::QDEPTH];
    logic [msd_pkg::QPW-1:0] r_wp;
    logic [msd_pkg::QPW-1:0] r_rp;
    logic [msd_pkg::QPW:0]   r_cnt;
    logic [msd_pkg::QPW:0]   n_cnt;
    logic                    do_push;
    logic                    do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_full       = (r_cnt == (msd_pkg::QPW+1)'(msd_pkg::QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.head  = r_mem[r_rp];

endmodule

>>> rtl/msd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_back
// Per-channel read-modify-write of the detector state and the result register.
// ----------------------------------------------------------------------------
module msd_back #(
    parameter int CHANNELS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msd_pkg::t_cfg      i_cfg,
    input  msd_pkg::t_q_head   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output msd_pkg::t_out_item o_out_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    msd_pkg::t_chan_state r_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_vld;
    msd_pkg::t_chan_state r_rd;
    logic                 r_rd_vld;

    logic                 r_b_valid;
    msd_pkg::t_q_entry    r_b_entry;

    logic                 r_fwd_valid;
    logic [AW-1:0]        r_fwd_idx;
    msd_pkg::t_chan_state r_fwd_data;

    logic                 r_out_valid;
    msd_pkg::t_out_item   r_out;

    logic                 out_free;
    logic                 fire;
    logic                 wr_en;
    logic [AW-1:0]        rd_idx;
    logic [AW-1:0]        b_idx;
    msd_pkg::t_chan_state cur;
    msd_pkg::t_chan_state nxt;
    logic [15:0]          since;
    logic [7:0]           run;
    logic                 qual;
    logic                 found;

    assign out_free = !r_out_valid || !i_out_stall;
    assign fire     = r_b_valid && out_free;
    assign o_pop    = i_head.valid && (!r_b_valid || fire);
    assign wr_en    = fire && r_b_entry.ch_ok;
    assign rd_idx   = AW'(i_head.head.channel);
    assign b_idx    = AW'(r_b_entry.channel);

    always_comb begin
        // Take the last write when it hit this channel; the registered read may predate it.
        if (r_fwd_valid && (r_fwd_idx == b_idx)) begin
            cur = r_fwd_data;
        end else if (r_rd_vld) begin
            cur = r_rd;
        end else begin
            cur = msd_pkg::CHAN_RESET;
        end

        since = cur.since + {15'd0, (cur.since != 16'hFFFF)};
        run   = cur.run + {7'd0, (cur.run != 8'hFF)};
        qual  = (since >= i_cfg.blanking) && r_b_entry.beyond;
        found = qual && (run >= i_cfg.run_needed);

        nxt       = cur;
        nxt.since = since;
        nxt.run   = qual ? run : 8'd0;
        if (found) begin
            nxt.since     = '0;
            nxt.run       = '0;
            nxt.count     = cur.count + 16'd1;
            nxt.last_scan = r_b_entry.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (fire) begin
                r_b_valid <= 1'b0;
            end
            if (wr_en) begin
                r_vld[b_idx] <= 1'b1;
                r_fwd_valid  <= 1'b1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // State memory: one write port from the update, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[b_idx] <= nxt;
        end
        if (o_pop) begin
            r_rd     <= r_mem[rd_idx];
            r_rd_vld <= r_vld[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_entry <= i_head.head;
        end
        if (wr_en) begin
            r_fwd_idx  <= b_idx;
            r_fwd_data <= nxt;
        end
        if (fire) begin
            r_out.out_channel <= r_b_entry.channel;
            r_out.scan_number <= r_b_entry.scan;
            if (r_b_entry.ch_ok) begin
                r_out.spike_found <= found;
                r_out.spike_total <= nxt.count;
                r_out.spike_scan  <= nxt.last_scan;
            end else begin
                r_out.spike_found <= 1'b0;
                r_out.spike_total <= '0;
                r_out.spike_scan  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/multichannel_spike_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_spike_detector_top
// Threshold spike detector with blanking over interleaved converter channels.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Payload
//   in        sink       i_in_valid/stall   t_in_item  (channel, sample, new_scan)
//   out       source     o_out_valid/stall  t_out_item (one result per sample)
//   cfg       sink       i_cfg_valid/ready  register index, write data
//
// One sample per cycle sustained while the output does not stall; a result
// passes the queue, the request register and the result register, using a
// registered state-memory read with forwarding of the previous write.
// Reset is synchronous; channel state reads as its reset value until first
// written (a valid flag per channel), so no clearing pass is needed.
// A two-entry queue lets the front keep taking requests while the output
// stalls; input stall rises once that queue fills.
// ----------------------------------------------------------------------------
module multichannel_spike_detector_top #(
    parameter int CHANNELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  msd_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output msd_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [msd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic              r_alive;
    msd_pkg::t_cfg     r_cfg;
    logic              in_accept;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    msd_pkg::t_q_entry q_entry;
    msd_pkg::t_q_head  q_head;

    // Hold off both sinks through reset and the cycle after it.
    assign o_in_stall  = !i_rst_n || !r_alive || q_full;
    assign o_cfg_ready = i_rst_n && r_alive;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
            r_cfg   <= msd_pkg::CFG_RESET;
        end else begin
            r_alive <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    msd_pkg::REG_THRESHOLD:     r_cfg.threshold     <= i_cfg_data;
                    msd_pkg::REG_BLANKING:      r_cfg.blanking      <= i_cfg_data;
                    msd_pkg::REG_POLARITY_HIGH: r_cfg.polarity_high <= i_cfg_data[0];
                    msd_pkg::REG_RUN_NEEDED:    r_cfg.run_needed    <= i_cfg_data[7:0];
                    default: begin
                        // drop writes to unknown registers
                    end
                endcase
            end
        end
    end

    msd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_push   (q_push),
        .o_entry  (q_entry)
    );

    msd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full)
    );

    msd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/msd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks on the spike detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "multichannel_spike_detector_top_assert.svh"

module msd_checker #(
    parameter int CHANNELS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input msd_pkg::t_out_item o_out_data
);

    logic [2:0] r_outst;
    logic       in_acc;
    logic       out_acc;
    logic       out_held;
    logic       outst_any;
    logic       spike_out;
    logic       scan_match;
    logic       bad_out;
    logic       bad_clear;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;
    assign out_held   = o_out_valid && i_out_stall;
    assign outst_any  = (r_outst != 3'd0);
    assign spike_out  = o_out_valid && o_out_data.spike_found;
    assign scan_match = (o_out_data.spike_scan == o_out_data.scan_number);
    assign bad_out    = o_out_valid && (32'(o_out_data.out_channel) >= CHANNELS);
    assign bad_clear  = !o_out_data.spike_found && (o_out_data.spike_total == 16'd0)
                        && (o_out_data.spike_scan == 32'd0);

    // Track requests taken but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + {2'd0, in_acc} - {2'd0, out_acc};
        end
    end

    `MSD_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    `MSD_ASSERT(a_out_hold, i_clk, i_rst_n, out_held |=> o_out_valid, "stalled result dropped")

    `MSD_ASSERT(a_no_extra_result, i_clk, i_rst_n, out_acc |-> outst_any, "orphan result")

    `MSD_ASSERT(a_spike_scan_now, i_clk, i_rst_n, spike_out |-> scan_match, "spike scan stale")

    `MSD_ASSERT(a_bad_channel_zero, i_clk, i_rst_n, bad_out |-> bad_clear, "bad channel result")

endmodule

bind multichannel_spike_detector_top msd_checker #(
    .CHANNELS (CHANNELS)
) u_msd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel threshold spike detector.
// A scoreboard tracks the per-channel detector state and the shared settings.
// It predicts one report per accepted sample and compares each report the
// block returns against the oldest pending one. Directed cases come first,
// then randomized scan traffic under several settings, with random input
// gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_CH      = 16;
    localparam int CYCLE_LIMIT = 600000;

    // Register indexes outside the decoded set; writes to them must be ignored.
    localparam logic [msd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd4;
    localparam logic [msd_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hFF;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    msd_pkg::t_in_item              i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    msd_pkg::t_out_item             o_out_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [msd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [msd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Scoreboard copy of the detector state and settings.
    msd_pkg::t_cfg cfg_copy = msd_pkg::CFG_RESET;
    logic [31:0] scan_ctr = '0;
    logic [15:0] since_cnt [NUM_CH];
    logic [7:0]  run_len   [NUM_CH];
    logic [15:0] spike_cnt [NUM_CH];
    logic [31:0] last_scan [NUM_CH];

    msd_pkg::t_out_item expected_reports[$];

    int          gap_pct   = 0;
    int          stall_pct = 0;
    int          mismatches      = 0;
    int          samples_sent    = 0;
    int          reports_checked = 0;
    int          spikes_seen     = 0;
    int          cfg_writes      = 0;
    int          cycle_count     = 0;

    multichannel_spike_detector_top #(
        .CHANNELS(NUM_CH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int c = 0; c < NUM_CH; c++) begin
            since_cnt[c] = 16'hFFFF;
            run_len[c]   = '0;
            spike_cnt[c] = '0;
            last_scan[c] = '0;
        end
    end

    // Advance the scoreboard by one sample and return the report it implies.
    function automatic msd_pkg::t_out_item score_sample(msd_pkg::t_in_item it);
        msd_pkg::t_out_item r;
        logic [15:0] since;
        logic [7:0]  run;
        logic        beyond;
        r = '0;
        if (it.new_scan) scan_ctr = scan_ctr + 32'd1;
        r.out_channel = it.channel;
        if (it.channel < NUM_CH) begin
            since = since_cnt[it.channel];
            if (since != 16'hFFFF) since = since + 16'd1;
            since_cnt[it.channel] = since;
            beyond = cfg_copy.polarity_high ? (it.sample > cfg_copy.threshold)
                                            : (it.sample < cfg_copy.threshold);
            if (since >= cfg_copy.blanking && beyond) begin
                run = run_len[it.channel];
                if (run != 8'hFF) run = run + 8'd1;
                run_len[it.channel] = run;
                if (run >= cfg_copy.run_needed) begin
                    spike_cnt[it.channel] = spike_cnt[it.channel] + 16'd1;
                    last_scan[it.channel] = scan_ctr;
                    since_cnt[it.channel] = '0;
                    run_len[it.channel]   = '0;
                    r.spike_found = 1'b1;
                end
            end else begin
                run_len[it.channel] = '0;
            end
            r.spike_total = spike_cnt[it.channel];
            r.spike_scan  = last_scan[it.channel];
        end
        r.scan_number = scan_ctr;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Settings writes, sample requests and reports, all seen at the rising edge.
    always @(posedge i_clk) begin : scoreboard
        msd_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    msd_pkg::REG_THRESHOLD:     cfg_copy.threshold     = i_cfg_data;
                    msd_pkg::REG_BLANKING:      cfg_copy.blanking      = i_cfg_data;
                    msd_pkg::REG_POLARITY_HIGH: cfg_copy.polarity_high = i_cfg_data[0];
                    msd_pkg::REG_RUN_NEEDED:    cfg_copy.run_needed    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                expected_reports.push_back(score_sample(i_in_data));
                samples_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("report with nothing pending: channel %0d",
                           o_out_data.out_channel);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("out_channel", 32'(want.out_channel),
                                32'(o_out_data.out_channel));
                    check_field("spike_found", 32'(want.spike_found),
                                32'(o_out_data.spike_found));
                    check_field("spike_total", 32'(want.spike_total),
                                32'(o_out_data.spike_total));
                    check_field("spike_scan", want.spike_scan, o_out_data.spike_scan);
                    check_field("scan_number", want.scan_number, o_out_data.scan_number);
                    reports_checked++;
                    if (o_out_data.spike_found) spikes_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports pending",
                     cycle_count, expected_reports.size());
            $display("FAIL multichannel_spike_detector_top");
            $finish;
        end
    end

    // Output backpressure in random bursts.
    initial begin
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // Leave valid high on return; the next call or a pause decides what follows.
    task automatic send_sample(input logic [3:0] ch, input logic [15:0] level,
                               input logic scan);
        @(negedge i_clk);
        i_in_valid         = 1'b1;
        i_in_data.channel  = ch;
        i_in_data.sample   = level;
        i_in_data.new_scan = scan;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic pause_input(input int cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off new requests until every pending report is back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [msd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [msd_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    task automatic load_settings(input logic [15:0] thr, input logic [15:0] blank,
                                 input logic [15:0] pol_word, input logic [15:0] run_word);
        wait_drained();
        cfg_write(msd_pkg::REG_THRESHOLD, thr);
        cfg_write(msd_pkg::REG_BLANKING, blank);
        cfg_write(msd_pkg::REG_POLARITY_HIGH, pol_word);
        cfg_write(msd_pkg::REG_RUN_NEEDED, run_word);
    endtask

    // Pick a level that does or does not cross the threshold under current settings.
    function automatic logic [15:0] pick_level(input bit crossing);
        logic [15:0] thr;
        thr = cfg_copy.threshold;
        if (cfg_copy.polarity_high) begin
            if (crossing && thr != 16'hFFFF) return 16'($urandom_range(65535, thr + 1));
            return crossing ? 16'($urandom) : 16'($urandom_range(thr, 0));
        end
        if (crossing && thr != 16'h0000) return 16'($urandom_range(thr - 1, 0));
        return crossing ? 16'($urandom) : 16'($urandom_range(65535, thr));
    endfunction

    // Bursts on one channel long enough to complete a spike, mixed with other traffic.
    task automatic run_traffic(input int count);
        int          burst_left;
        int          r;
        logic [3:0]  burst_ch;
        logic [3:0]  ch;
        logic [15:0] level;
        burst_left = 0;
        burst_ch   = '0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_ch   = 4'($urandom);
                burst_left = int'(cfg_copy.run_needed) + $urandom_range(1, 3);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                ch    = burst_ch;
                level = pick_level(r < 63);
                burst_left--;
            end else if (r < 90) begin
                ch    = 4'($urandom);
                level = pick_level(1'($urandom_range(0, 1)));
            end else begin
                ch    = 4'($urandom);
                level = 16'($urandom);
            end
            send_sample(ch, level, $urandom_range(0, 7) == 0);
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                pause_input($urandom_range(1, 19));
        end
    endtask

    task automatic test_reset_settings();
        stall_pct = 15;
        send_sample(4'd0, 16'hFFFF, 1'b1);
        send_sample(4'd0, 16'hFFFF, 1'b0);
        send_sample(4'd15, 16'h0000, 1'b1);
        send_sample(4'd0, 16'd32769, 1'b0);
        send_sample(4'd0, 16'hFFFF, 1'b0);
        send_sample(4'd15, 16'd32768, 1'b0);
    endtask

    task automatic test_polarity_low();
        load_settings(16'hFFFF, 16'd0, 16'd0, 16'd2);
        send_sample(4'd3, 16'hFFFE, 1'b1);
        send_sample(4'd3, 16'h0000, 1'b0);
        send_sample(4'd3, 16'hFFFF, 1'b0);
        send_sample(4'd4, 16'h0000, 1'b1);
        send_sample(4'd4, 16'h0000, 1'b0);
        load_settings(16'h0000, 16'd0, 16'd0, 16'd1);
        send_sample(4'd3, 16'h0000, 1'b0);
    endtask

    // A run length of zero must act like one.
    task automatic test_short_runs();
        load_settings(16'h0000, 16'd0, 16'd1, 16'd0);
        send_sample(4'd7, 16'd1, 1'b1);
        send_sample(4'd7, 16'd1, 1'b0);
        send_sample(4'd7, 16'd0, 1'b0);
        load_settings(16'h0000, 16'd0, 16'd1, 16'd1);
        send_sample(4'd8, 16'hFFFF, 1'b1);
    endtask

    task automatic test_blanking();
        load_settings(16'd100, 16'd3, 16'd1, 16'd1);
        send_sample(4'd5, 16'd200, 1'b1);
        send_sample(4'd5, 16'd200, 1'b1);
        send_sample(4'd5, 16'd200, 1'b0);
        send_sample(4'd5, 16'd200, 1'b1);
        // Only a channel that never spiked sits at the saturated count.
        load_settings(16'd100, 16'hFFFF, 16'd1, 16'd1);
        send_sample(4'd6, 16'd101, 1'b0);
        send_sample(4'd6, 16'd101, 1'b0);
    endtask

    task automatic test_unknown_register();
        wait_drained();
        cfg_write(CFG_IDX_UNUSED, 16'h0000);
        cfg_write(CFG_IDX_TOP, 16'hFFFF);
        send_sample(4'd9, 16'd101, 1'b0);
        send_sample(4'd9, 16'd99, 1'b1);
    endtask

    // Longest run setting: break one run, then complete one across interleaved traffic.
    task automatic test_long_run();
        int q;
        load_settings(16'($urandom_range(0, 60000)), 16'd0, 16'd1, 16'd255);
        gap_pct   = 10;
        stall_pct = 10;
        for (int i = 0; i < 40; i++) begin
            send_sample(4'd9, pick_level(1'b1), $urandom_range(0, 7) == 0);
        end
        send_sample(4'd9, pick_level(1'b0), 1'b0);
        q = 0;
        while (q < 256) begin
            if ($urandom_range(0, 99) < 25) begin
                send_sample(4'($urandom_range(10, 15)), 16'($urandom), $urandom_range(0, 7) == 0);
            end else begin
                send_sample(4'd9, pick_level(1'b1), $urandom_range(0, 7) == 0);
                q++;
            end
            if ($urandom_range(0, 99) < gap_pct) pause_input($urandom_range(1, 19));
        end
    endtask

    task automatic test_random_phases();
        logic [15:0] thr;
        logic [15:0] blank;
        logic        pol;
        logic [7:0]  run;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    thr = 16'($urandom); blank = 16'd0; pol = 1'b1; run = 8'd1;
                    gap_pct = 10; stall_pct = 10;
                end
                1: begin
                    thr = 16'h0000; blank = 16'd1; pol = 1'b1; run = 8'd2;
                    gap_pct = 35; stall_pct = 35;
                end
                2: begin
                    thr = 16'hFFFF; blank = 16'($urandom_range(2, 12)); pol = 1'b0; run = 8'd4;
                    gap_pct = 0; stall_pct = 0;
                end
                3: begin
                    thr = 16'($urandom); blank = 16'($urandom_range(0, 3)); pol = 1'($urandom);
                    run = 8'd0; gap_pct = 5; stall_pct = 50;
                end
                default: begin
                    thr = 16'($urandom); blank = 16'($urandom_range(0, 12)); pol = 1'($urandom);
                    run = 8'($urandom_range(1, 6)); gap_pct = 20; stall_pct = 5;
                end
            endcase
            // Upper bits of the narrow registers carry noise that must be dropped.
            load_settings(thr, blank, {15'($urandom), pol}, {8'($urandom), run});
            cfg_write(8'($urandom_range(4, 255)), 16'($urandom));
            run_traffic(65);
            wait_drained();
            run_traffic(65);
        end
    endtask

    task automatic test_final_calm();
        gap_pct   = 0;
        stall_pct = 0;
        load_settings(16'($urandom), 16'($urandom_range(0, 8)), 16'($urandom_range(0, 1)),
                      16'($urandom_range(1, 4)));
        run_traffic(100);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_settings();
        test_polarity_low();
        test_short_runs();
        test_blanking();
        test_unknown_register();
        test_long_run();
        test_random_phases();
        test_final_calm();

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d reports never arrived", expected_reports.size());
            mismatches++;
        end
        $display("Covered %0d samples and %0d reports with %0d spikes,", samples_sent,
                 reports_checked, spikes_seen);
        $display("across %0d settings writes in %0d cycles; %0d mismatches.", cfg_writes,
                 cycle_count, mismatches);
        if (mismatches == 0) begin
            $display("PASS multichannel_spike_detector_top");
        end else begin
            $display("FAIL multichannel_spike_detector_top");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/msd_pkg.sv
rtl/msd_front.sv
rtl/msd_queue.sv
rtl/msd_back.sv
rtl/multichannel_spike_detector_top.sv
rtl/msd_checker.sv
test/tb.sv
